// File: sv/wfe_pkg.sv
// Package for the LED strip frame encoder.
// Holds request codes, config and result structs, register map constants.
// No dependencies.
package wfe_pkg;

    localparam int WORD_W = 32;
    localparam int PCS_W  = 9;
    localparam int BC_W   = 5;

    typedef enum logic [1:0] {
        REQ_SET_ONE = 2'd0,
        REQ_SET_ALL = 2'd1,
        REQ_START   = 2'd2,
        REQ_TICK    = 2'd3
    } t_req_e;

    // register indexes (byte address is 4 * index)
    localparam logic [1:0] REG_PERIOD_TOP    = 2'd0;
    localparam logic [1:0] REG_RESET_PERIODS = 2'd1;
    localparam logic [1:0] REG_RGBW_MODE     = 2'd2;

    localparam logic [7:0] PERIOD_TOP_RST    = 8'd89;
    localparam logic [7:0] RESET_PERIODS_RST = 8'd40;
    localparam logic       RGBW_MODE_RST     = 1'b0;

    localparam logic [BC_W-1:0] BITS_RGB  = 5'd24;
    localparam logic [BC_W-1:0] BITS_RGBW = 5'd0;  // 32 wraps to zero in 5 bits

    // multiply-by-reciprocal for divide by 3, exact below 512
    localparam logic [7:0] DIV3_MUL = 8'd171;
    localparam int         DIV3_SHR = 9;

    typedef struct packed {
        logic [7:0] period_top;
        logic [7:0] reset_periods;
        logic       rgbw_mode;
    } t_cfg;

    typedef struct packed {
        logic       frame_end;
        logic       busy_res;
        logic       accepted;
        logic       line_active;
        logic [7:0] duty;
    } t_result;

endpackage

// File: sv/wfe_pixel_mem.sv
// Pixel colour store: synchronous RAM with per-entry valid bits and a
// broadcast word for set-all, plus a bypass for a write that meets a read.
// Depends on wfe_pkg.
module wfe_pixel_mem #(
    parameter int PIXEL_COUNT = 16,
    parameter int AW          = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    input  logic                      i_wr_one,
    input  logic                      i_wr_all,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [wfe_pkg::WORD_W-1:0] i_wr_word,
    output logic [wfe_pkg::WORD_W-1:0] o_rd_word
);
    import wfe_pkg::*;

    logic [WORD_W-1:0]      r_mem [PIXEL_COUNT];
    logic [PIXEL_COUNT-1:0] r_valid;
    logic [WORD_W-1:0]      r_all_word;
    logic [WORD_W-1:0]      r_rd_data;
    logic [AW-1:0]          r_rd_addr;
    logic                   r_byp;
    logic [WORD_W-1:0]      r_byp_word;

    always_ff @(posedge i_clk) begin
        if (i_wr_one) begin
            r_mem[i_wr_addr] <= i_wr_word;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_rd_addr  <= i_rd_addr;
            r_byp_word <= i_wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_all_word <= '0;
            r_byp      <= 1'b0;
        end else begin
            if (i_wr_all) begin
                r_valid    <= '0;
                r_all_word <= i_wr_word;
            end else if (i_wr_one) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                // RAM returns old data when written in the same cycle
                r_byp <= i_wr_one && (i_wr_addr == i_rd_addr);
            end
        end
    end

    assign o_rd_word = r_byp               ? r_byp_word :
                       r_valid[r_rd_addr]  ? r_rd_data  : r_all_word;

endmodule

// File: sv/wfe_frame_seq.sv
// Frame sequencer: lead reset, pixel bits, trail reset; produces the duty
// stream and status per request. Depends on wfe_pkg.
module wfe_frame_seq #(
    parameter int PIXEL_COUNT = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,
    input  wfe_pkg::t_req_e            i_req,
    input  wfe_pkg::t_cfg              i_cfg,
    input  logic [wfe_pkg::WORD_W-1:0] i_pix_word,
    output logic [wfe_pkg::PCS_W-1:0]  o_next_pcs,
    output wfe_pkg::t_result           o_result
);
    import wfe_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_LEAD  = 2'd1,
        PH_DATA  = 2'd2,
        PH_TRAIL = 2'd3
    } t_phase_e;

    localparam logic [PCS_W-1:0] PCS_END = PCS_W'(PIXEL_COUNT);

    t_phase_e          r_phase, n_phase;
    logic [7:0]        r_pc, n_pc;
    logic [PCS_W-1:0]  r_pcs, n_pcs;
    logic [BC_W-1:0]   r_bc, n_bc;
    logic [WORD_W-1:0] r_sw, n_sw;

    logic [7:0]        rlen, pc1, d_half, d_one, d_zero;
    logic [16:0]       prod_zero, prod_one;
    logic [BC_W-1:0]   bc1, total;
    logic [PCS_W-1:0]  pcs1;
    logic [WORD_W-1:0] sw_use;
    t_result           res;

    assign rlen      = (i_cfg.reset_periods == 8'd0) ? 8'd1 : i_cfg.reset_periods;
    assign d_half    = {1'b0, i_cfg.period_top[7:1]};
    assign prod_zero = {9'd0, i_cfg.period_top} * {9'd0, DIV3_MUL};
    assign prod_one  = {8'd0, i_cfg.period_top, 1'b0} * {9'd0, DIV3_MUL};
    assign d_zero    = prod_zero[DIV3_SHR +: 8];
    assign d_one     = prod_one[DIV3_SHR +: 8];
    assign total     = i_cfg.rgbw_mode ? BITS_RGBW : BITS_RGB;
    assign pc1       = r_pc + 8'd1;
    assign bc1       = r_bc + 5'd1;
    assign pcs1      = r_pcs + 9'd1;
    assign sw_use    = (r_bc != '0) ? r_sw : ((r_pcs < PCS_END) ? i_pix_word : '0);

    always_comb begin
        n_phase = r_phase;
        n_pc    = r_pc;
        n_pcs   = r_pcs;
        n_bc    = r_bc;
        n_sw    = r_sw;
        res     = '0;
        unique case (i_req)
            REQ_SET_ONE, REQ_SET_ALL: begin
                // acceptance of writes is decided at the top level
            end
            REQ_START: begin
                if (r_phase == PH_IDLE) begin
                    n_phase      = PH_LEAD;
                    n_pc         = '0;
                    n_pcs        = '0;
                    n_bc         = '0;
                    res.accepted = 1'b1;
                end
            end
            REQ_TICK: begin
                unique case (r_phase)
                    PH_IDLE: begin
                    end
                    PH_LEAD: begin
                        res.line_active = 1'b1;
                        res.duty        = (r_pc == 8'd0) ? d_half : 8'd0;
                        n_pc            = pc1;
                        if (pc1 >= rlen) begin
                            n_phase = PH_DATA;
                            n_pc    = '0;
                            n_pcs   = '0;
                            n_bc    = '0;
                        end
                    end
                    PH_DATA: begin
                        res.line_active = 1'b1;
                        res.duty        = sw_use[WORD_W-1] ? d_one : d_zero;
                        n_sw            = {sw_use[WORD_W-2:0], 1'b0};
                        n_bc            = bc1;
                        // total of zero stands for the full 32-bit pixel
                        if (bc1 == '0 || (total != '0 && bc1 >= total)) begin
                            n_bc  = '0;
                            n_pcs = pcs1;
                            if (pcs1 >= PCS_END) begin
                                n_phase = PH_TRAIL;
                                n_pc    = '0;
                            end
                        end
                    end
                    PH_TRAIL: begin
                        res.line_active = 1'b1;
                        n_pc            = pc1;
                        if (pc1 >= rlen) begin
                            n_phase       = PH_IDLE;
                            n_pc          = '0;
                            n_pcs         = '0;
                            res.frame_end = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        res.busy_res = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pc    <= '0;
            r_pcs   <= '0;
            r_bc    <= '0;
            r_sw    <= '0;
        end else if (i_go) begin
            r_phase <= n_phase;
            r_pc    <= n_pc;
            r_pcs   <= n_pcs;
            r_bc    <= n_bc;
            r_sw    <= n_sw;
        end
    end

    assign o_next_pcs = i_go ? n_pcs : r_pcs;
    assign o_result   = res;

endmodule

// File: sv/ws2812_pwm_frame_encoder_unit.sv
// LED strip frame encoder top: stream in/out, APB config, pixel RAM, sequencer.
// Requests are held in the execute register, results in the output register; throughput
// one item per cycle unless m_axis_tready stalls. The next request's pixel read is issued
// at the input transfer (registered RAM read), with a bypass for a write from the request ahead of it.
// Reset (synchronous, active low) clears control state, valid bits and config;
// no clearing pass. Depends on wfe_pkg, wfe_pixel_mem, wfe_frame_seq.
module ws2812_pwm_frame_encoder_unit #(
    parameter int PIXEL_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // pixel_index, red, green, blue, white
    input  logic [1:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // duty, line_active, accepted, busy_res,
                                        // frame_end, zero fill
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wfe_pkg::*;

    localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam logic [8:0] PIX_END = 9'(PIXEL_COUNT);

    t_cfg              r_cfg;
    logic              r_e_valid;
    t_req_e            r_e_req;
    logic [7:0]        r_e_idx;
    logic [WORD_W-1:0] r_e_word;
    logic              r_o_valid;
    logic [15:0]       r_o_data;

    logic              in_xfer, e_go, wr_one, wr_all, idx_ok;
    logic [PCS_W-1:0]  next_pcs;
    logic [WORD_W-1:0] pix_word;
    t_result           seq_res, res;

    // APB config
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_top    <= PERIOD_TOP_RST;
            r_cfg.reset_periods <= RESET_PERIODS_RST;
            r_cfg.rgbw_mode     <= RGBW_MODE_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                REG_PERIOD_TOP:    r_cfg.period_top    <= pwdata[7:0];
                REG_RESET_PERIODS: r_cfg.reset_periods <= pwdata[7:0];
                REG_RGBW_MODE:     r_cfg.rgbw_mode     <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_PERIOD_TOP:    prdata = {24'd0, r_cfg.period_top};
            REG_RESET_PERIODS: prdata = {24'd0, r_cfg.reset_periods};
            REG_RGBW_MODE:     prdata = {31'd0, r_cfg.rgbw_mode};
            default:           prdata = '0;
        endcase
    end

    // execute stage advances when the output register is free or drains
    assign e_go          = r_e_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_e_valid || e_go;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_e_valid <= s_axis_tvalid;
        end
    end

    // stored word is G, R, B, W from the top byte down
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_e_req  <= t_req_e'(s_axis_tuser);
            r_e_idx  <= s_axis_tdata[7:0];
            r_e_word <= {s_axis_tdata[23:16], s_axis_tdata[15:8],
                         s_axis_tdata[31:24], s_axis_tdata[39:32]};
        end
    end

    assign idx_ok = ({1'b0, r_e_idx} < PIX_END);
    assign wr_one = e_go && (r_e_req == REQ_SET_ONE) && idx_ok;
    assign wr_all = e_go && (r_e_req == REQ_SET_ALL);

    wfe_pixel_mem #(
        .PIXEL_COUNT(PIXEL_COUNT),
        .AW         (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_xfer),
        .i_rd_addr (next_pcs[AW-1:0]),
        .i_wr_one  (wr_one),
        .i_wr_all  (wr_all),
        .i_wr_addr (r_e_idx[AW-1:0]),
        .i_wr_word (r_e_word),
        .o_rd_word (pix_word)
    );

    wfe_frame_seq #(
        .PIXEL_COUNT(PIXEL_COUNT)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (e_go),
        .i_req      (r_e_req),
        .i_cfg      (r_cfg),
        .i_pix_word (pix_word),
        .o_next_pcs (next_pcs),
        .o_result   (seq_res)
    );

    always_comb begin
        res = seq_res;
        if (r_e_req == REQ_SET_ONE) begin
            res.accepted = idx_ok;
        end else if (r_e_req == REQ_SET_ALL) begin
            res.accepted = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (e_go) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_go) begin
            r_o_data <= {4'd0, res.frame_end, res.busy_res, res.accepted,
                         res.line_active, res.duty};
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;

endmodule
